>>> rtl/crq_pkg.sv
// Shared constants, types and helpers for the character ring queue.
package crq_pkg;

    localparam int DEPTH  = 128;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;
    localparam int CAP_W  = 8;
    localparam int STAT_W = 2;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(100);

    localparam logic [KIND_W-1:0] KIND_PUSH     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PUSH_NEW = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_DUP   = 2'd3
    } t_status;

    typedef struct packed {
        logic    cfg_wr;
        logic    push;
        logic    use_saved;
        logic    pop_rd;
        logic    scan_start;
        logic    scan_step;
        logic    out_load;
        logic    out_from_mem;
        t_status out_status;
    } t_dp_cmd;

    typedef struct packed {
        logic occ_zero;
        logic full;
        logic rd_match;
        logic scan_last;
    } t_dp_sts;

    function automatic logic [ADDR_W-1:0] f_adv(
        input logic [ADDR_W-1:0] idx,
        input logic [CNT_W-1:0]  cap
    );
        logic [CNT_W-1:0] n;
        begin
            n = {1'b0, idx} + CNT_W'(1);
            return (n >= cap) ? '0 : n[ADDR_W-1:0];
        end
    endfunction

endpackage

>>> rtl/crq_in_if.sv
// Request channel: operation kind and character byte.
interface crq_in_if import crq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

>>> rtl/crq_out_if.sv
// Result channel: status code and popped byte.
interface crq_out_if import crq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] data;

    modport source (output valid, output status, output data, input ready);
    modport sink   (input valid, input status, input data, output ready);
endinterface

>>> rtl/crq_cfg_if.sv
// Configuration write channel carrying the capacity register.
interface crq_cfg_if import crq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

>>> rtl/crq_ctrl.sv
// Controller state machine sequencing push, pop and duplicate scan.
module crq_ctrl import crq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [KIND_W-1:0] i_in_kind,
    output logic              o_in_ready,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  t_dp_sts           i_sts,
    output t_dp_cmd           o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    logic    accept;
    t_dp_cmd cmd;

    always_comb begin
        o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
        o_cfg_ready = (r_state == S_IDLE) && !i_in_valid;
        accept      = i_in_valid && o_in_ready;
        n_state     = r_state;
        cmd         = '0;
        cmd.out_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    cmd.out_load = 1'b1;
                    case (i_in_kind)
                        KIND_PUSH: begin
                            if (i_sts.full) begin
                                cmd.out_status = ST_FULL;
                            end else begin
                                cmd.push = 1'b1;
                            end
                        end
                        KIND_POP: begin
                            if (i_sts.occ_zero) begin
                                cmd.out_status = ST_EMPTY;
                            end else begin
                                cmd.out_load = 1'b0;
                                cmd.pop_rd   = 1'b1;
                                n_state      = S_POP;
                            end
                        end
                        KIND_PUSH_NEW: begin
                            if (i_sts.occ_zero) begin
                                cmd.push = 1'b1;
                            end else begin
                                cmd.out_load   = 1'b0;
                                cmd.scan_start = 1'b1;
                                n_state        = S_SCAN;
                            end
                        end
                        default: begin
                            cmd.out_status = ST_OK;
                        end
                    endcase
                end else if (i_cfg_valid && o_cfg_ready) begin
                    cmd.cfg_wr = 1'b1;
                end
            end
            S_POP: begin
                cmd.out_load     = 1'b1;
                cmd.out_from_mem = 1'b1;
                n_state          = S_IDLE;
            end
            S_SCAN: begin
                if (i_sts.rd_match) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_DUP;
                    n_state        = S_IDLE;
                end else if (i_sts.scan_last) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                    if (i_sts.full) begin
                        cmd.out_status = ST_FULL;
                    end else begin
                        cmd.push      = 1'b1;
                        cmd.use_saved = 1'b1;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

>>> rtl/crq_dp.sv
// Datapath: slot memory, queue pointers, scan counter and result register.
module crq_dp import crq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [BYTE_W-1:0] i_value,
    input  logic [CAP_W-1:0]  i_cap_data,
    output t_dp_sts           o_sts,
    output logic [STAT_W-1:0] o_status,
    output logic [BYTE_W-1:0] o_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] wr_data;

    logic [CNT_W-1:0]  r_cap, n_cap;
    logic [ADDR_W-1:0] r_head, n_head;
    logic [ADDR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0]  r_occ, n_occ;
    logic [ADDR_W-1:0] r_scan_addr, n_scan_addr;
    logic [CNT_W-1:0]  r_left, n_left;
    logic [BYTE_W-1:0] r_val;
    logic [STAT_W-1:0] r_status;
    logic [BYTE_W-1:0] r_data;
    logic [CMP_W-1:0]  cap_wide;

    always_comb begin
        cap_wide = CMP_W'(i_cap_data);
        if (cap_wide == '0) begin
            n_cap = CNT_W'(1);
        end else if (cap_wide > CMP_W'(DEPTH)) begin
            n_cap = CNT_W'(DEPTH);
        end else begin
            n_cap = cap_wide[CNT_W-1:0];
        end

        rd_addr = i_cmd.scan_step ? f_adv(r_scan_addr, r_cap) : r_head;
        wr_data = i_cmd.use_saved ? r_val : i_value;

        n_head      = r_head;
        n_tail      = r_tail;
        n_occ       = r_occ;
        n_scan_addr = r_scan_addr;
        n_left      = r_left;
        if (i_cmd.push) begin
            n_tail = f_adv(r_tail, r_cap);
            n_occ  = r_occ + CNT_W'(1);
        end
        if (i_cmd.pop_rd) begin
            n_head = f_adv(r_head, r_cap);
            n_occ  = r_occ - CNT_W'(1);
        end
        if (i_cmd.scan_start) begin
            n_scan_addr = r_head;
            n_left      = r_occ;
        end
        if (i_cmd.scan_step) begin
            n_scan_addr = rd_addr;
            n_left      = r_left - CNT_W'(1);
        end

        o_sts.occ_zero  = (r_occ == '0);
        o_sts.full      = (r_occ >= r_cap);
        o_sts.rd_match  = (r_rd_data == r_val);
        o_sts.scan_last = (r_left == CNT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_tail] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CNT_W'(CAP_RESET);
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
        end else if (i_cmd.cfg_wr) begin
            r_cap  <= n_cap;
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_occ  <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_addr <= n_scan_addr;
        r_left      <= n_left;
        if (i_cmd.scan_start) begin
            r_val <= i_value;
        end
        if (i_cmd.out_load) begin
            r_status <= i_cmd.out_status;
            r_data   <= i_cmd.out_from_mem ? r_rd_data : '0;
        end
    end

    assign o_status = r_status;
    assign o_data   = r_data;

endmodule

>>> rtl/char_ring_queue_with_dedup_insert.sv
// Top level of the character ring queue with duplicate-suppressing insert.
// Push, unused kind and pop on empty: the result is registered directly from the beat.
// Pop: a registered slot-memory read, then the result register loads from it in S_POP.
// Push-if-new: scans the live slots from head, one live slot read per cycle; a match ends it early.
// Next beat once idle with the result register free: push 1 per cycle; a pop holds it off through S_POP.
// Reset clears pointers, occupancy and result valid, capacity returns to 100; slots are kept.
module char_ring_queue_with_dedup_insert import crq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    crq_in_if.sink   i_in,
    crq_out_if.source o_out,
    crq_cfg_if.sink  i_cfg
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    crq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_kind   (i_in.kind),
        .o_in_ready  (i_in.ready),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    crq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_value    (i_in.value),
        .i_cap_data (i_cfg.capacity),
        .o_sts      (sts),
        .o_status   (o_out.status),
        .o_data     (o_out.data)
    );

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the character ring queue with duplicate-suppressing insert.
module tb_top import crq_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam real PERIOD = 12.0;
    localparam int RESET_CYCLES = 7;
    localparam int QUIET_LIMIT = 2000;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int PRINT_LIMIT = 50;
    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] value;
    } queue_req_t;

    typedef struct {
        t_status           status;
        logic [BYTE_W-1:0] data;
    } queue_reply_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic              req_valid = 1'b0;
    logic [KIND_W-1:0] req_kind = '0;
    logic [BYTE_W-1:0] req_value = '0;
    logic              res_ready = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [CAP_W-1:0]  cfg_cap = '0;

    crq_in_if  in_if ();
    crq_out_if out_if ();
    crq_cfg_if cfg_if ();

    assign in_if.valid     = req_valid;
    assign in_if.kind      = req_kind;
    assign in_if.value     = req_value;
    assign out_if.ready    = res_ready;
    assign cfg_if.valid    = cfg_valid;
    assign cfg_if.capacity = cfg_cap;

    char_ring_queue_with_dedup_insert dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #(PERIOD / 2.0) i_clk = ~i_clk;

    queue_req_t   req_backlog[$];
    queue_reply_t awaited_replies[$];
    int           mismatch_count = 0;

    logic [BYTE_W-1:0] mirror_slot [DEPTH];
    int                mirror_head = 0;
    int                mirror_tail = 0;
    int                mirror_count = 0;
    logic [CAP_W-1:0]  mirror_cap = CAP_RESET;

    function automatic int live_capacity();
        if (mirror_cap == 0) return 1;
        if (int'(mirror_cap) > DEPTH) return DEPTH;
        return int'(mirror_cap);
    endfunction

    function automatic int wrap_next(input int idx, input int c);
        return (idx + 1 >= c) ? 0 : idx + 1;
    endfunction

    function automatic t_status store_byte(input logic [BYTE_W-1:0] value, input int c);
        if (mirror_count >= c) return ST_FULL;
        mirror_slot[mirror_tail] = value;
        mirror_tail = wrap_next(mirror_tail, c);
        mirror_count++;
        return ST_OK;
    endfunction

    function automatic queue_reply_t apply_queue_op(input logic [KIND_W-1:0] kind,
                                                    input logic [BYTE_W-1:0] value);
        queue_reply_t r;
        int c;
        int idx;
        bit hit;
        c = live_capacity();
        r.status = ST_OK;
        r.data = '0;
        hit = 1'b0;
        case (kind)
            KIND_PUSH: begin
                r.status = store_byte(value, c);
            end
            KIND_POP: begin
                if (mirror_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data = mirror_slot[mirror_head];
                    mirror_head = wrap_next(mirror_head, c);
                    mirror_count--;
                end
            end
            KIND_PUSH_NEW: begin
                idx = mirror_head;
                for (int i = 0; i < mirror_count; i++) begin
                    if (mirror_slot[idx] == value) hit = 1'b1;
                    idx = wrap_next(idx, c);
                end
                r.status = hit ? ST_DUP : store_byte(value, c);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic int pick_gap(inout bit calm);
        int r;
        if ($urandom_range(0, 199) == 0) calm = ~calm;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Sender: offer backlog beats with random gaps
    int tx_gap = 0;
    bit tx_calm = 1'b0;

    always @(posedge i_clk) begin : driver
        queue_req_t item;
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else if (!req_valid || in_if.ready) begin
            if (tx_gap > 0) begin
                tx_gap--;
                req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
                item = req_backlog.pop_front();
                req_valid <= 1'b1;
                req_kind <= item.kind;
                req_value <= item.value;
                tx_gap = pick_gap(tx_calm);
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    int rx_stall = 0;
    bit rx_calm = 1'b0;
    bit squeeze_req = 1'b0;
    bit squeeze_done = 1'b0;
    int squeeze_left = 0;

    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (squeeze_req && !squeeze_done) begin
                squeeze_left = SQUEEZE_CYCLES;
                squeeze_done = 1'b1;
            end
            if (squeeze_left > 0) begin
                squeeze_left--;
                res_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
                rx_stall = pick_gap(rx_calm);
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        queue_reply_t want;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (awaited_replies.size() == 0) begin
                    report_mismatch($sformatf(
                        "result beat with nothing outstanding (status %0d data %0d)",
                        out_if.status, out_if.data));
                end else begin
                    want = awaited_replies.pop_front();
                    if (out_if.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %s",
                                                  out_if.status, want.status.name()));
                    if (out_if.data !== want.data)
                        report_mismatch($sformatf("data %0d, want %0d", out_if.data, want.data));
                end
            end
            if (in_if.valid && in_if.ready)
                awaited_replies.push_back(apply_queue_op(in_if.kind, in_if.value));
            if (cfg_if.valid && cfg_if.ready) begin
                mirror_cap = cfg_if.capacity;
                mirror_head = 0;
                mirror_tail = 0;
                mirror_count = 0;
            end
        end
    end

    int quiet_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic queue_op(input logic [KIND_W-1:0] kind, input int value);
        queue_req_t item;
        item.kind = kind;
        item.value = BYTE_W'(value);
        req_backlog.push_back(item);
    endtask

    function automatic int pick_char();
        if ($urandom_range(0, 1) == 0) return $urandom_range(0, 255);
        return $urandom_range(8'h41, 8'h48);
    endfunction

    task automatic add_random_ops(input int n, input int push_w, input int pop_w);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 3) queue_op(KIND_NOP, $urandom_range(0, 255));
            else if (r < 3 + push_w) queue_op(KIND_PUSH, pick_char());
            else if (r < 3 + push_w + pop_w) queue_op(KIND_POP, $urandom_range(0, 255));
            else queue_op(KIND_PUSH_NEW, pick_char());
        end
    endtask

    // Fill past full, then drain past empty
    task automatic add_fill_drain(input int c);
        repeat (c + 2) begin
            if ($urandom_range(0, 1) == 0) queue_op(KIND_PUSH, $urandom_range(0, 255));
            else queue_op(KIND_PUSH_NEW, $urandom_range(0, 255));
        end
        repeat (c + 2) queue_op(KIND_POP, $urandom_range(0, 255));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (req_backlog.size() != 0 || req_valid || awaited_replies.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_capacity(input int value);
        wait_drained();
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_cap <= CAP_W'(value);
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : sequencer
        int caps[12];
        int c;
        int eff;
        caps = '{1, 0, 128, 255, 3, 7, 100, 16, 200, 1, 1, 64};
        caps[9] = $urandom_range(1, 40);
        caps[10] = $urandom_range(1, 40);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_op(KIND_POP, 8'h00);
        queue_op(KIND_PUSH, 8'h00);
        queue_op(KIND_PUSH, 8'hFF);
        queue_op(KIND_PUSH_NEW, 8'hFF);
        queue_op(KIND_PUSH_NEW, 8'h00);
        queue_op(KIND_PUSH_NEW, 8'h5A);
        queue_op(KIND_NOP, 8'hAA);
        queue_op(KIND_POP, 8'h00);
        queue_op(KIND_POP, 8'h00);
        queue_op(KIND_POP, 8'h00);
        queue_op(KIND_POP, 8'hFF);

        set_capacity(2);
        queue_op(KIND_PUSH, 8'h01);
        queue_op(KIND_PUSH, 8'h80);
        queue_op(KIND_PUSH, 8'h7F);
        queue_op(KIND_PUSH_NEW, 8'h80);
        queue_op(KIND_PUSH_NEW, 8'h33);
        queue_op(KIND_POP, 8'h00);
        queue_op(KIND_PUSH_NEW, 8'h01);
        queue_op(KIND_NOP, 8'h55);
        queue_op(KIND_POP, 8'h00);
        queue_op(KIND_POP, 8'h00);
        queue_op(KIND_POP, 8'h00);

        foreach (caps[p]) begin
            c = caps[p];
            eff = (c == 0) ? 1 : ((c > DEPTH) ? DEPTH : c);
            set_capacity(c);
            add_random_ops(20, 50, 20);
            add_fill_drain(eff);
            add_random_ops(20, 20, 50);
            if (p == 3) squeeze_req = 1'b1;
        end

        wait_drained();
        repeat (DEPTH + 4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
